[rtl/awmmt_pkg.sv]
package awmmt_pkg;

	localparam int VW   = 32;
	localparam int AGEW = 32;
	localparam int MIW  = 10;
	localparam int CNTW = 10;
	localparam int CFGW = 32;

	typedef enum logic [1:0] {
		REG_MAX_AGE     = 2'd0,
		REG_MAX_ITEMS   = 2'd1,
		REG_WIN_MIN_AGE = 2'd2,
		REG_WIN_MAX_AGE = 2'd3
	} cfg_reg_t;

	localparam logic [AGEW-1:0] MAX_AGE_RST     = 32'd2500000;
	localparam logic [MIW-1:0]  MAX_ITEMS_RST   = 10'd500;
	localparam logic [AGEW-1:0] WIN_MIN_AGE_RST = 32'd0;
	localparam logic [AGEW-1:0] WIN_MAX_AGE_RST = 32'hFFFF_FFFF;

	localparam logic [VW-1:0] VAL_MOST_NEG = 32'h8000_0000;
	localparam logic [VW-1:0] VAL_MOST_POS = 32'h7FFF_FFFF;

endpackage

[rtl/aged_window_max_min_avg_tracker_top.sv]
// Sliding age window tracker. Each request carries a Q16.16 sample, its initial age and the
// elapsed time in microseconds; the block appends the sample to a ring of DEPTH entries, drops
// old entries by count and front age, ages every entry with saturation, drops again, then scans
// the entries inside [window_min_age, window_max_age] and returns max, min, truncated average and
// count. An item is processed in turn: the prune checks drop entries one at a time, then the
// aging and scan passes each walk the single-port sample memory, and the serial divider runs
// only when the window is not empty. s_tready stays low until the item is done, so requests
// are handled one at a time. The result sits in an output
// register, and the next request is taken while it waits. Configuration writes belong to idle
// time.
module aged_window_max_min_avg_tracker_top #(
	parameter int DEPTH = 512
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  awmmt_pkg::cfg_reg_t         cfg_index,
	input  logic [awmmt_pkg::CFGW-1:0]  cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// sample_value, sample_age, elapsed
	input  logic [95:0]                 s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// window_max, window_min, window_avg, window_count, zero pad
	output logic [111:0]                m_tdata
);
	import awmmt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = VW + AW + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRUNE_RD,
		ST_PRUNE_CHK,
		ST_PRUNE_END,
		ST_AGE,
		ST_SCAN,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [AGEW-1:0] max_age_q;
	logic [MIW-1:0]  max_items_q;
	logic [AGEW-1:0] win_min_q;
	logic [AGEW-1:0] win_max_q;

	logic [AW-1:0]   oldest_q;
	logic [CW-1:0]   occ_q;
	logic [VW-1:0]   last_avg_q;
	logic            pass2_q;
	logic [AGEW-1:0] elapsed_q;
	logic [AW-1:0]   ptr_q;
	logic [CW-1:0]   k_q;
	logic            valid_s1;
	logic [AW-1:0]   addr_s1;

	logic signed [VW-1:0] hi_q;
	logic signed [VW-1:0] lo_q;
	logic signed [SW-1:0] sum_q;
	logic [CW-1:0]        n_q;
	logic                 div_start_q;
	logic                 m_tvalid_q;
	logic [111:0]         m_tdata_q;

	logic [VW-1:0]   val_mem [DEPTH];
	logic [AGEW-1:0] age_mem [DEPTH];
	logic [VW-1:0]   val_rd_q;
	logic [AGEW-1:0] age_rd_q;

	logic [VW-1:0]   in_value;
	logic [AGEW-1:0] in_age;
	logic [AGEW-1:0] in_elapsed;

	logic            accept;
	logic            occ_full;
	logic [AW-1:0]   oldest_app;
	logic [CW-1:0]   occ_app;
	logic [CW:0]     pos_sum;
	logic [CW:0]     pos_wrap;
	logic [AW-1:0]   pos_app;

	logic            val_we;
	logic            age_we;
	logic [AW-1:0]   wa;
	logic [AGEW-1:0] age_wd;
	logic [AW-1:0]   ra;

	logic [AGEW:0]   age_add;
	logic [AGEW-1:0] age_sat;
	logic            occ_over;
	logic            drop;
	logic            in_win;
	logic            issue;
	logic signed [VW-1:0] val_s;

	logic          div_done;
	logic [VW-1:0] div_quo;
	logic [CW+CNTW-1:0] n_ext;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_value   = s_tdata[31:0];
	assign in_age     = s_tdata[63:32];
	assign in_elapsed = s_tdata[95:64];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// the full ring gives up its oldest entry before the append
	assign occ_full   = (occ_q == CW'(DEPTH));
	assign oldest_app = occ_full ? wrap_inc(oldest_q) : oldest_q;
	assign occ_app    = occ_full ? occ_q - 1'b1 : occ_q;
	assign pos_sum    = (CW + 1)'(oldest_app) + (CW + 1)'(occ_app);
	assign pos_wrap   = pos_sum - (CW + 1)'(DEPTH);
	assign pos_app    = (pos_sum >= (CW + 1)'(DEPTH)) ? pos_wrap[AW-1:0] : pos_sum[AW-1:0];

	assign age_add  = {1'b0, age_rd_q} + {1'b0, elapsed_q};
	assign age_sat  = age_add[AGEW] ? '1 : age_add[AGEW-1:0];
	assign occ_over = {{MIW{1'b0}}, occ_q} > {{CW{1'b0}}, max_items_q};
	assign drop     = occ_over || (age_rd_q > max_age_q);
	assign in_win   = (age_rd_q >= win_min_q) && (age_rd_q <= win_max_q);
	assign issue    = (k_q != occ_q);
	assign val_s    = $signed(val_rd_q);

	always_comb begin
		val_we = 1'b0;
		age_we = 1'b0;
		wa     = pos_app;
		age_wd = in_age;
		ra     = (state_q == ST_PRUNE_RD) ? oldest_q : ptr_q;
		if (accept) begin
			val_we = 1'b1;
			age_we = 1'b1;
		end else if (state_q == ST_AGE && valid_s1) begin
			age_we = 1'b1;
			wa     = addr_s1;
			age_wd = age_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[wa] <= in_value;
		end
		if (age_we) begin
			age_mem[wa] <= age_wd;
		end
		val_rd_q <= val_mem[ra];
		age_rd_q <= age_mem[ra];
	end

	awmmt_div #(
		.NW(SW),
		.DW(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (sum_q),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign n_ext = {{CNTW{1'b0}}, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_age_q   <= MAX_AGE_RST;
			max_items_q <= MAX_ITEMS_RST;
			win_min_q   <= WIN_MIN_AGE_RST;
			win_max_q   <= WIN_MAX_AGE_RST;
			oldest_q    <= '0;
			occ_q       <= '0;
			last_avg_q  <= '0;
			pass2_q     <= 1'b0;
			valid_s1    <= 1'b0;
			div_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_AGE:     max_age_q   <= cfg_data;
					REG_MAX_ITEMS:   max_items_q <= cfg_data[MIW-1:0];
					REG_WIN_MIN_AGE: win_min_q   <= cfg_data;
					REG_WIN_MAX_AGE: win_max_q   <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						elapsed_q <= in_elapsed;
						oldest_q  <= oldest_app;
						occ_q     <= occ_app + 1'b1;
						pass2_q   <= 1'b0;
						state_q   <= ST_PRUNE_RD;
					end
				end
				ST_PRUNE_RD: begin
					state_q <= (occ_q == '0) ? ST_PRUNE_END : ST_PRUNE_CHK;
				end
				ST_PRUNE_CHK: begin
					if (drop) begin
						oldest_q <= wrap_inc(oldest_q);
						occ_q    <= occ_q - 1'b1;
						state_q  <= ST_PRUNE_RD;
					end else begin
						state_q <= ST_PRUNE_END;
					end
				end
				ST_PRUNE_END: begin
					ptr_q    <= oldest_q;
					k_q      <= '0;
					valid_s1 <= 1'b0;
					hi_q     <= $signed(VAL_MOST_NEG);
					lo_q     <= $signed(VAL_MOST_POS);
					sum_q    <= '0;
					n_q      <= '0;
					state_q  <= pass2_q ? ST_SCAN : ST_AGE;
				end
				ST_AGE, ST_SCAN: begin
					if (issue) begin
						ptr_q    <= wrap_inc(ptr_q);
						k_q      <= k_q + 1'b1;
						valid_s1 <= 1'b1;
						addr_s1  <= ptr_q;
					end else begin
						valid_s1 <= 1'b0;
					end
					if (state_q == ST_SCAN && valid_s1 && in_win) begin
						sum_q <= sum_q + {{(SW - VW){val_s[VW-1]}}, val_s};
						n_q   <= n_q + 1'b1;
						if (val_s > hi_q) begin
							hi_q <= val_s;
						end
						if (val_s < lo_q) begin
							lo_q <= val_s;
						end
					end
					if (!issue && !valid_s1) begin
						if (state_q == ST_AGE) begin
							pass2_q <= 1'b1;
							state_q <= ST_PRUNE_RD;
						end else if (n_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						last_avg_q <= div_quo;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {6'd0, n_ext[CNTW-1:0], last_avg_q, lo_q, hi_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/awmmt_div.sv]
module awmmt_div #(
	parameter int NW = 42,
	parameter int DW = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NW-1:0]           dividend,
	input  logic [DW-1:0]           divisor,
	output logic                    done,
	output logic [awmmt_pkg::VW-1:0] quotient
);
	import awmmt_pkg::*;

	localparam int CNTB = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic            neg_q;
	logic [CNTB-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;

	logic [NW-1:0] mag;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_diff;
	logic          ge;

	assign mag      = dividend[NW-1] ? (~dividend + 1'b1) : dividend;
	assign rem_sh   = {rem_q, quo_q[NW-1]};
	assign rem_diff = rem_sh - {1'b0, divisor};
	assign ge       = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTB'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTB'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			neg_q <= dividend[NW-1];
			quo_q <= mag;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q[VW-1:0] + 1'b1) : quo_q[VW-1:0];

endmodule

[rtl/awmmt_chk.sv]
module awmmt_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata
);

	// one request at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// a result that follows a taken one is loaded only as the block goes idle
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid || s_tready)
		else $error("result loaded while busy");

	// average lies between min and max when the window holds samples
	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[105:96] != 10'd0) |->
			($signed(m_tdata[31:0]) >= $signed(m_tdata[95:64])) &&
			($signed(m_tdata[95:64]) >= $signed(m_tdata[63:32])))
		else $error("average outside min/max");

	// no new result right after a request is taken
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid || !$rose(m_tvalid))
		else $error("result appeared right after request");

endmodule

bind aged_window_max_min_avg_tracker_top awmmt_chk u_awmmt_chk (.*);
